/* hdl/grid_packing_first_fit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef GRID_PACKING_FIRST_FIT_ASSERT_SVH
`define GRID_PACKING_FIRST_FIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GPFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define GPFF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* hdl/gpff_pkg.sv */
package gpff_pkg;

  // Map and patch store sizes.
  localparam int MAX_MAP_COLS   = 64;
  localparam int MAX_MAP_ROWS   = 64;
  localparam int MAX_PATCH_SIDE = 32;

  // Fixed field widths.
  localparam int CFG_W  = 7;
  localparam int CS_W   = 12;
  localparam int PIX_W  = 18;
  localparam int VAL_W  = 7;
  localparam int KIND_W = 2;
  localparam int CELL_W = 5;
  localparam int PDIM_W = 6;
  localparam int IDX_W  = 2;

  // Derived widths.
  localparam int CW    = $clog2(MAX_MAP_COLS + 1);
  localparam int RW    = $clog2(MAX_MAP_ROWS + 1);
  localparam int PW    = $clog2(MAX_PATCH_SIDE + 1);
  localparam int PI_W  = (MAX_PATCH_SIDE > 1) ? $clog2(MAX_PATCH_SIDE) : 1;
  localparam int MAP_DEPTH   = MAX_MAP_COLS * MAX_MAP_ROWS;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int PATCH_DEPTH = MAX_PATCH_SIDE * MAX_PATCH_SIDE;
  localparam int PATCH_AW    = (PATCH_DEPTH > 1) ? $clog2(PATCH_DEPTH) : 1;
  localparam int CLR_DEPTH   = (MAP_DEPTH > PATCH_DEPTH) ? MAP_DEPTH : PATCH_DEPTH;
  localparam int CLR_W       = $clog2(CLR_DEPTH);
  localparam int PROD_W      = (CW + CS_W > PIX_W) ? CW + CS_W : PIX_W;
  localparam int DIV_STEPS   = PIX_W;
  localparam int DIV_W       = $clog2(DIV_STEPS);
  localparam int QDEPTH      = 4;
  localparam int QA_W        = $clog2(QDEPTH);

  localparam logic [VAL_W-1:0] RUN_MAX   = 7'd127;
  localparam logic [VAL_W-1:0] VALUE_MAX = 7'd64;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_FIND   = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_MAP_COLS  = 2'd0,
    REG_MAP_ROWS  = 2'd1,
    REG_CELL_SIZE = 2'd2
  } reg_idx_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic [PW-1:0]       pc;
    logic [PW-1:0]       pr;
    logic [PIX_W-1:0]    sx;
    logic [PIX_W-1:0]    sy;
    logic [VAL_W-1:0]    value;
    logic [PATCH_AW-1:0] paddr;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIVX,
    FR_DIVY,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FIND_ROW,
    BK_FIND_RD,
    BK_FIND_EV,
    BK_FIND_OUT,
    BK_CM_RD,
    BK_CM_EV,
    BK_OC_EV,
    BK_WK_RD,
    BK_WK_EV
  } bk_state_t;

  function automatic logic [MAP_AW-1:0] map_addr(input logic [CW-1:0] col,
                                                 input logic [RW-1:0] row);
    return MAP_AW'(int'(row) * MAX_MAP_COLS + int'(col));
  endfunction

  function automatic logic [PATCH_AW-1:0] patch_addr(input logic [PI_W-1:0] col,
                                                     input logic [PI_W-1:0] row);
    return PATCH_AW'(int'(row) * MAX_PATCH_SIDE + int'(col));
  endfunction

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 7'd1;
  endfunction

  function automatic logic [PW-1:0] clamp_patch(input logic [PDIM_W-1:0] v);
    if (v == '0) return PW'(1);
    if (int'(v) > MAX_PATCH_SIDE) return PW'(MAX_PATCH_SIDE);
    return PW'(v);
  endfunction

endpackage

/* hdl/gpff_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
module gpff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/gpff_front.sv */
// Front end: accepts requests, classifies them and converts commit origins
// from pixels to cells with a shared bit-serial divider.
module gpff_front import gpff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              hold,
  input  logic [KIND_W-1:0] kind,
  input  logic [CELL_W-1:0] cell_col,
  input  logic [CELL_W-1:0] cell_row,
  input  logic [VAL_W-1:0]  cell_value,
  input  logic [PDIM_W-1:0] patch_cols,
  input  logic [PDIM_W-1:0] patch_rows,
  input  logic [PIX_W-1:0]  pixel_x,
  input  logic [PIX_W-1:0]  pixel_y,
  input  logic [CS_W-1:0]   cell_size,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  fr_state_t state, state_next;
  cmd_t cmd;
  logic [PIX_W-1:0] dvd;
  logic [CS_W-1:0]  rem;
  logic [CS_W-1:0]  dcs;
  logic [DIV_W-1:0] cnt;

  logic             accept;
  logic             load_ok;
  logic [CS_W:0]    trial;
  logic             ge;
  logic [CS_W-1:0]  rem_next;
  logic [PIX_W-1:0] dvd_next;
  logic             div_last;

  assign in_ready = (state == FR_IDLE) && !hold;
  assign accept   = in_valid && in_ready;
  assign load_ok  = (int'(cell_col) < MAX_PATCH_SIDE) && (int'(cell_row) < MAX_PATCH_SIDE);
  assign push     = (state == FR_PUSH) && !q_full;
  assign push_cmd = cmd;

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem, dvd[PIX_W-1]};
    ge       = trial >= {1'b0, dcs};
    rem_next = ge ? CS_W'(trial - {1'b0, dcs}) : CS_W'(trial);
    dvd_next = {dvd[PIX_W-2:0], ge};
    div_last = (cnt == DIV_W'(DIV_STEPS - 1));
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (accept) begin
          if (kind == OP_LOAD) begin
            if (load_ok) state_next = FR_PUSH;
          end else if (kind == OP_FIND) begin
            state_next = FR_PUSH;
          end else if (kind == OP_COMMIT) begin
            state_next = FR_DIVX;
          end
        end
      end
      FR_DIVX: if (div_last) state_next = FR_DIVY;
      FR_DIVY: if (div_last) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // Request capture and divider datapath.
  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        if (accept) begin
          cmd.op    <= op_t'(kind);
          cmd.pc    <= clamp_patch(patch_cols);
          cmd.pr    <= clamp_patch(patch_rows);
          cmd.sx    <= pixel_x;
          cmd.sy    <= pixel_y;
          cmd.value <= (cell_value > VALUE_MAX) ? VALUE_MAX : cell_value;
          cmd.paddr <= patch_addr(PI_W'(cell_col), PI_W'(cell_row));
          dvd       <= pixel_x;
          rem       <= '0;
          cnt       <= '0;
          dcs       <= (cell_size == '0) ? CS_W'(1) : cell_size;
        end
      end
      FR_DIVX: begin
        if (div_last) begin
          cmd.sx <= dvd_next;
          dvd    <= cmd.sy;
          rem    <= '0;
          cnt    <= '0;
        end else begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + DIV_W'(1);
        end
      end
      FR_DIVY: begin
        if (div_last) begin
          cmd.sy <= dvd_next;
        end else begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + DIV_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/gpff_queue.sv */
// Short request queue between the front and the back.
module gpff_queue import gpff_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t            slots [QDEPTH];
  logic [QA_W-1:0] wptr;
  logic [QA_W-1:0] rptr;
  logic [QA_W:0]   count;

  assign full    = (count == (QA_W + 1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QA_W'(1);
      if (pop) rptr <= rptr + QA_W'(1);
      if (push && !pop) count <= count + (QA_W + 1)'(1);
      else if (pop && !push) count <= count - (QA_W + 1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

endmodule

/* hdl/gpff_back.sv */
// Back end: clears the stores after reset, then executes load, find and
// commit requests against the occupancy map and the patch store.
module gpff_back import gpff_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] cfg_cols,
  input  logic [CFG_W-1:0] cfg_rows,
  input  logic [CS_W-1:0]  cfg_cell,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [PIX_W-1:0] place_x,
  output logic [PIX_W-1:0] place_y
);

  bk_state_t state, state_next;

  logic [CW-1:0]   cols;
  logic [RW-1:0]   rows;
  logic [CS_W-1:0] cs;

  logic [CLR_W-1:0] clr_cnt;
  logic [PW-1:0]    pc;
  logic [PW-1:0]    pr;
  logic [CW-1:0]    x;
  logic [RW-1:0]    y;
  logic [PI_W-1:0]  c;
  logic [PI_W-1:0]  r;
  logic             hit_found;
  logic [CW-1:0]    gx;
  logic [RW-1:0]    gy;
  logic [CW-1:0]    sx0;
  logic [CW-1:0]    ex;
  logic [RW-1:0]    ey;
  logic [PI_W-1:0]  dc;
  logic [PI_W-1:0]  dr;
  logic [CW-1:0]    wx;
  logic [VAL_W-1:0] val;

  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic [VAL_W-1:0]    map_wdata;
  logic [MAP_AW-1:0]   map_raddr;
  logic [VAL_W-1:0]    map_rd;
  logic                patch_we;
  logic [PATCH_AW-1:0] patch_waddr;
  logic [VAL_W-1:0]    patch_wdata;
  logic [PATCH_AW-1:0] patch_raddr;
  logic [VAL_W-1:0]    patch_rd;

  logic out_free;
  logic too_big;
  logic cm_start;
  logic f_row_over;
  logic f_col_over;
  logic f_hit;
  logic f_skip_row;
  logic f_c_more;
  logic f_r_more;
  logic [CW+VAL_W:0] f_nx;
  logic c_occ;
  logic c_gx_more;
  logic c_last;
  logic gx_at_end;

  // Clamped configuration.
  always_comb begin
    if (cfg_cols == '0) cols = CW'(1);
    else if (int'(cfg_cols) > MAX_MAP_COLS) cols = CW'(MAX_MAP_COLS);
    else cols = CW'(cfg_cols);
    if (cfg_rows == '0) rows = RW'(1);
    else if (int'(cfg_rows) > MAX_MAP_ROWS) rows = RW'(MAX_MAP_ROWS);
    else rows = RW'(cfg_rows);
    cs = (cfg_cell == '0) ? CS_W'(1) : cfg_cell;
  end

  assign clearing = (state == BK_CLEAR);
  assign pop      = (state == BK_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  // Decision terms for find and commit.
  always_comb begin
    too_big    = (int'(q_cmd.pc) > int'(cols)) || (int'(q_cmd.pr) > int'(rows));
    cm_start   = (int'(q_cmd.sx) < int'(cols)) && (int'(q_cmd.sy) < int'(rows));
    f_row_over = (int'(y) + int'(pr)) > int'(rows);
    f_col_over = (int'(x) + int'(pc)) > int'(cols);
    f_hit      = (map_rd != '0) && (patch_rd != '0);
    f_nx       = (CW + VAL_W + 1)'(int'(x) + int'(map_rd) + int'(patch_rd) - 1);
    f_skip_row = (int'(f_nx) + int'(pc)) > int'(cols);
    f_c_more   = (int'(c) + 1) < int'(pc);
    f_r_more   = (int'(r) + 1) < int'(pr);
    c_occ      = (patch_rd != '0) && (map_rd == '0);
    c_gx_more  = (int'(gx) + 1) < int'(ex);
    c_last     = !c_gx_more && !((int'(gy) + 1) < int'(ey));
    gx_at_end  = (int'(gx) == int'(cols) - 1);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_FIND:   state_next = too_big ? BK_FIND_OUT : BK_FIND_ROW;
            OP_COMMIT: state_next = cm_start ? BK_CM_RD : BK_IDLE;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_FIND_ROW: begin
        if (f_row_over) state_next = BK_FIND_OUT;
        else if (!f_col_over) state_next = BK_FIND_RD;
      end
      BK_FIND_RD: state_next = BK_FIND_EV;
      BK_FIND_EV: begin
        if (f_hit) state_next = BK_FIND_ROW;
        else if (f_c_more || f_r_more) state_next = BK_FIND_RD;
        else state_next = BK_FIND_OUT;
      end
      BK_FIND_OUT: if (out_free) state_next = BK_IDLE;
      BK_CM_RD: state_next = BK_CM_EV;
      BK_CM_EV: begin
        if (c_occ) state_next = gx_at_end ? BK_WK_RD : BK_OC_EV;
        else state_next = c_last ? BK_IDLE : BK_CM_RD;
      end
      BK_OC_EV: state_next = BK_WK_RD;
      BK_WK_RD: begin
        if (wx == '0) state_next = c_last ? BK_IDLE : BK_CM_RD;
        else state_next = BK_WK_EV;
      end
      BK_WK_EV: begin
        if (map_rd == '0) state_next = c_last ? BK_IDLE : BK_CM_RD;
        else state_next = BK_WK_RD;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    map_we      = 1'b0;
    map_waddr   = map_addr(gx, gy);
    map_wdata   = '0;
    map_raddr   = map_addr(gx, gy);
    patch_we    = 1'b0;
    patch_waddr = q_cmd.paddr;
    patch_wdata = q_cmd.value;
    patch_raddr = patch_addr(dc, dr);
    case (state)
      BK_CLEAR: begin
        map_we      = int'(clr_cnt) < MAP_DEPTH;
        map_waddr   = MAP_AW'(clr_cnt);
        patch_we    = int'(clr_cnt) < PATCH_DEPTH;
        patch_waddr = PATCH_AW'(clr_cnt);
        patch_wdata = '0;
      end
      BK_IDLE: patch_we = q_valid && (q_cmd.op == OP_LOAD);
      BK_FIND_RD: begin
        map_raddr   = map_addr(CW'(int'(x) + int'(c)), RW'(int'(y) + int'(r)));
        patch_raddr = patch_addr(c, r);
      end
      BK_CM_EV: begin
        map_raddr = map_addr(gx + CW'(1), gy);
        map_we    = c_occ && gx_at_end;
        map_wdata = VAL_W'(1);
      end
      BK_OC_EV: begin
        map_we    = 1'b1;
        map_wdata = sat_inc(map_rd);
      end
      BK_WK_RD: map_raddr = map_addr(wx - CW'(1), gy);
      BK_WK_EV: begin
        map_we    = map_rd != '0;
        map_waddr = map_addr(wx - CW'(1), gy);
        map_wdata = sat_inc(val);
      end
      default: begin
      end
    endcase
  end

  // Clear counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);
      if (state == BK_FIND_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        pc        <= q_cmd.pc;
        pr        <= q_cmd.pr;
        x         <= '0;
        y         <= '0;
        c         <= '0;
        r         <= '0;
        hit_found <= 1'b0;
        gx        <= CW'(q_cmd.sx);
        gy        <= RW'(q_cmd.sy);
        sx0       <= CW'(q_cmd.sx);
        dc        <= '0;
        dr        <= '0;
        ex        <= ((int'(q_cmd.sx) + int'(q_cmd.pc)) < int'(cols)) ?
                     CW'(int'(q_cmd.sx) + int'(q_cmd.pc)) : cols;
        ey        <= ((int'(q_cmd.sy) + int'(q_cmd.pr)) < int'(rows)) ?
                     RW'(int'(q_cmd.sy) + int'(q_cmd.pr)) : rows;
      end
      BK_FIND_ROW: begin
        if (f_row_over) begin
          x <= '0;
          y <= '0;
        end else if (f_col_over) begin
          x <= '0;
          y <= y + RW'(1);
        end else begin
          c <= '0;
          r <= '0;
        end
      end
      BK_FIND_EV: begin
        if (f_hit) begin
          if (f_skip_row) begin
            x <= '0;
            y <= y + RW'(1);
          end else begin
            x <= CW'(f_nx);
          end
        end else if (f_c_more) begin
          c <= c + PI_W'(1);
        end else if (f_r_more) begin
          c <= '0;
          r <= r + PI_W'(1);
        end else begin
          hit_found <= 1'b1;
        end
      end
      BK_FIND_OUT: begin
        if (out_free) begin
          found   <= hit_found;
          place_x <= PIX_W'(PROD_W'(x) * PROD_W'(cs));
          place_y <= PIX_W'(PROD_W'(y) * PROD_W'(cs));
        end
      end
      BK_CM_EV: begin
        if (c_occ) begin
          wx <= gx;
          val <= VAL_W'(1);
        end
      end
      BK_OC_EV: begin
        wx  <= gx;
        val <= sat_inc(map_rd);
      end
      BK_WK_EV: begin
        if (map_rd != '0) begin
          wx  <= wx - CW'(1);
          val <= sat_inc(val);
        end
      end
      default: begin
      end
    endcase
    // Step to the next patch cell once the current one is settled.
    if ((state == BK_CM_EV && !c_occ) || (state == BK_WK_RD && wx == '0) ||
        (state == BK_WK_EV && map_rd == '0)) begin
      if (c_gx_more) begin
        gx <= gx + CW'(1);
        dc <= dc + PI_W'(1);
      end else begin
        gx <= sx0;
        dc <= '0;
        gy <= gy + RW'(1);
        dr <= dr + PI_W'(1);
      end
    end
  end

  gpff_ram #(.WIDTH(VAL_W), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

  gpff_ram #(.WIDTH(VAL_W), .DEPTH(PATCH_DEPTH)) u_patch_ram (
    .clk   (clk),
    .we    (patch_we),
    .waddr (patch_waddr),
    .wdata (patch_wdata),
    .raddr (patch_raddr),
    .rdata (patch_rd)
  );

endmodule

/* hdl/grid_packing_first_fit.sv */
// First-fit patch placement on a grid occupancy map. After reset the block
// clears the map and patch store, with in_ready low. A commit passes
// through the front end's one-bit-per-cycle divider, which converts the
// pixel origin to cells, then visits each patch cell in the map memory.
// Each newly occupied cell passes through BK_OC_EV, except at the right
// map edge, where BK_CM_EV writes it directly. The leftward run-length
// walk then reads and updates the cells to its left until it meets a free
// cell or column 0. A find compares map cells with one registered read of
// each memory per comparison, steps through candidate origins and rows,
// and then presents its result. The queue between front and back holds 4
// requests, so loads and commits stream in while a find is still scanning.
module grid_packing_first_fit import gpff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [CELL_W-1:0] cell_col,
  input  logic [CELL_W-1:0] cell_row,
  input  logic [VAL_W-1:0]  cell_value,
  input  logic [PDIM_W-1:0] patch_cols,
  input  logic [PDIM_W-1:0] patch_rows,
  input  logic [PIX_W-1:0]  pixel_x,
  input  logic [PIX_W-1:0]  pixel_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [PIX_W-1:0]  place_x,
  output logic [PIX_W-1:0]  place_y,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CS_W-1:0]   cfg_data
);

  logic [CFG_W-1:0] map_cols;
  logic [CFG_W-1:0] map_rows;
  logic [CS_W-1:0]  cell_size;

  logic clearing;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_cols  <= CFG_W'(64);
      map_rows  <= CFG_W'(64);
      cell_size <= CS_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_COLS:  map_cols  <= cfg_data[CFG_W-1:0];
        REG_MAP_ROWS:  map_rows  <= cfg_data[CFG_W-1:0];
        REG_CELL_SIZE: cell_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpff_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hold       (clearing),
    .kind       (kind),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .cell_value (cell_value),
    .patch_cols (patch_cols),
    .patch_rows (patch_rows),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .cell_size  (cell_size),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  gpff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  gpff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_cols  (map_cols),
    .cfg_rows  (map_rows),
    .cfg_cell  (cell_size),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .place_x   (place_x),
    .place_y   (place_y)
  );

endmodule

/* hdl/gpff_checker.sv */
// Port-level checks on the placement block.
`include "grid_packing_first_fit_assert.svh"

module gpff_checker import gpff_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             found,
  input logic [PIX_W-1:0] place_x,
  input logic [PIX_W-1:0] place_y
);

  // A stalled result keeps its fields.
  `GPFF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(place_x) && $stable(place_y) && $stable(found), "stalled result changed")

  // A failed find reports a zero origin.
  `GPFF_ASSERT_IMPL(a_nofit_zero, out_valid && !found, place_x == '0 && place_y == '0, "no-fit result with nonzero origin")

  // Reset drops any pending result.
  `GPFF_ASSERT_RST(a_rst_out, !out_valid, "result valid right after reset")

  // The clearing pass blocks requests right after reset.
  `GPFF_ASSERT_RST(a_rst_in, !in_ready, "request accepted during clearing pass")

endmodule

bind grid_packing_first_fit gpff_checker u_checker (.*);
